>>> rtl/pagerank_partition_engine_macros.svh
// Assertion macros used by the checker of the partition engine.
`ifndef PAGERANK_PARTITION_ENGINE_MACROS_SVH
`define PAGERANK_PARTITION_ENGINE_MACROS_SVH

// Same-cycle implication: b must hold whenever a holds.
`define PPE_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication violated");

// Next-cycle implication: b must hold in the cycle after a holds.
`define PPE_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle implication violated");

`endif

>>> rtl/ppe_pkg.sv
// Package of the partition engine: sizes, request and result codes, states, structs.
`default_nettype none
package ppe_pkg;

  localparam int MAX_NODES  = 4096;
  localparam int ADDR_W     = $clog2(MAX_NODES);
  localparam int NCOUNT_W   = 13;
  localparam int SCORE_W    = 32;
  localparam int DEGREE_W   = 16;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 80;
  localparam int CFG_IDX_W  = 3;

  // Request types carried in the input tuser
  localparam logic [2:0] REQ_EDGE   = 3'd0;
  localparam logic [2:0] REQ_REMOTE = 3'd1;
  localparam logic [2:0] REQ_END    = 3'd2;
  localparam logic [2:0] REQ_READ   = 3'd3;
  localparam logic [2:0] REQ_INIT   = 3'd4;

  // Result kinds carried in the output tuser
  localparam logic [1:0] KIND_REMOTE = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MY_PARTITION  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_NODE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TELEPORT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SCORE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER      = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCORE,
    ST_DIV,
    ST_ACC,
    ST_READ,
    ST_END_RD,
    ST_END_MUL,
    ST_END_WR,
    ST_END_FIN,
    ST_INIT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic                start;
    logic [SCORE_W-1:0]  dividend;
    logic [DEGREE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [SCORE_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

>>> rtl/ppe_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module ppe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/ppe_div.sv
// Restoring divider, one quotient bit per cycle, for the edge share.
`default_nettype none
module ppe_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ppe_pkg::div_req_t req,
  output ppe_pkg::div_rsp_t      rsp
);
  import ppe_pkg::*;

  localparam int CNT_W = $clog2(SCORE_W);

  logic                busy;
  logic [CNT_W-1:0]    count;
  logic [DEGREE_W-1:0] rem;
  logic [DEGREE_W-1:0] divisor;
  logic [SCORE_W-1:0]  quo;
  logic                done;
  logic [DEGREE_W:0]   shifted;
  logic                fits;

  // Shift in the next dividend bit and trial-subtract
  assign shifted = {rem, quo[SCORE_W-1]};
  assign fits    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CNT_W'(SCORE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      quo     <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= fits ? DEGREE_W'(shifted - {1'b0, divisor}) : shifted[DEGREE_W-1:0];
      quo <= {quo[SCORE_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
`default_nettype wire

>>> rtl/pagerank_partition_engine.sv
// Remote requests run ST_ACC; reads ST_READ; edges ST_SCORE, ST_DIV (divider loop)
// and ST_ACC (accumulator read-modify-write); end of iteration ST_END_RD, ST_END_MUL
// and ST_END_WR per active node plus ST_END_FIN; initialise makes one write per entry
// of both RAMs. One request at a time. Throughput is set by the divider loop and the
// single write port of each RAM. Reset clears the control state and loads the
// register defaults; RAM contents stay undefined until an initialise request.
`default_nettype none
module pagerank_partition_engine (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // tdata: local_index, out_degree, target_node, target_partition, importance_q30
  input  wire logic [ppe_pkg::IN_DATA_W-1:0]    s_tdata,
  // tuser: req_type
  input  wire logic [2:0]                       s_tuser,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // tdata: dest_partition, dest_node, value_q30, more_iterations
  output logic      [ppe_pkg::OUT_DATA_W-1:0]   m_tdata,
  // tuser: kind
  output logic      [1:0]                       m_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ppe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [31:0]                      cfg_data
);
  import ppe_pkg::*;

  state_t state, state_next;

  // Configuration registers
  logic [7:0]          my_partition;
  logic [31:0]         first_node;
  logic [NCOUNT_W-1:0] node_count;
  logic [15:0]         damping_q16;
  logic [30:0]         teleport_q30;
  logic [30:0]         initial_score_q30;
  logic [15:0]         max_iterations;
  logic [15:0]         iteration_count;

  // Request fields
  logic [ADDR_W-1:0]   in_lidx;
  logic [DEGREE_W-1:0] in_degree;
  logic [31:0]         in_tnode;
  logic [7:0]          in_tpart;
  logic [31:0]         in_imp;
  logic [31:0]         in_diff;
  logic                in_local_ok;
  logic                in_lidx_ok;

  logic                accept;
  logic [NCOUNT_W-1:0] n_act;

  // Latched request
  logic [DEGREE_W-1:0] r_degree;
  logic [31:0]         r_tnode;
  logic [7:0]          r_tpart;
  logic [31:0]         r_diff;
  logic                r_local_ok;

  logic [ADDR_W-1:0]   acc_idx;
  logic [31:0]         add_amt;
  logic [ADDR_W-1:0]   walk_idx;
  logic                walk_last;
  logic [48:0]         prod;
  logic [16:0]         keep;
  logic [33:0]         upd_sum;
  logic [31:0]         upd_score;
  logic [32:0]         acc_sum;
  logic [31:0]         acc_sat;
  logic [15:0]         iter_inc;

  // Pending result
  logic [1:0]          res_kind;
  logic [7:0]          res_part;
  logic [31:0]         res_node;
  logic [31:0]         res_value;
  logic                res_more;

  // RAM ports
  logic                score_we, acc_we;
  logic [ADDR_W-1:0]   score_wa, acc_wa, score_ra, acc_ra;
  logic [31:0]         score_wd, acc_wd, score_rd, acc_rd;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign in_lidx   = s_tdata[11:0];
  assign in_degree = s_tdata[27:12];
  assign in_tnode  = s_tdata[59:28];
  assign in_tpart  = s_tdata[67:60];
  assign in_imp    = s_tdata[99:68];

  assign n_act       = (node_count > NCOUNT_W'(MAX_NODES)) ? NCOUNT_W'(MAX_NODES) : node_count;
  assign in_diff     = in_tnode - first_node;
  assign in_local_ok = in_diff < {{(32-NCOUNT_W){1'b0}}, n_act};
  assign in_lidx_ok  = {{(NCOUNT_W-ADDR_W){1'b0}}, in_lidx} < n_act;
  assign r_diff      = r_tnode - first_node;
  assign r_local_ok  = r_diff < {{(32-NCOUNT_W){1'b0}}, n_act};

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign walk_last = ({{(NCOUNT_W-ADDR_W){1'b0}}, walk_idx} + 1'b1) == n_act;
  assign keep      = 17'h10000 - {1'b0, damping_q16};
  assign upd_sum   = {1'b0, prod[48:16]} + {3'b0, teleport_q30};
  assign upd_score = (upd_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : upd_sum[31:0];
  assign acc_sum   = {1'b0, acc_rd} + {1'b0, add_amt};
  assign acc_sat   = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
  assign iter_inc  = (iteration_count == 16'hFFFF) ? iteration_count : iteration_count + 1'b1;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (s_tuser)
            REQ_EDGE:   state_next = (in_degree != '0 && in_lidx_ok) ? ST_SCORE : ST_IDLE;
            REQ_REMOTE: state_next = in_local_ok ? ST_ACC : ST_IDLE;
            REQ_END:    state_next = (n_act != '0) ? ST_END_RD : ST_END_FIN;
            REQ_READ:   state_next = in_lidx_ok ? ST_READ : ST_RESULT;
            REQ_INIT:   state_next = ST_INIT;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCORE: state_next = ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) begin
          if (r_tpart == my_partition) begin
            state_next = r_local_ok ? ST_ACC : ST_IDLE;
          end else begin
            state_next = ST_RESULT;
          end
        end
      end
      ST_ACC:     state_next = ST_IDLE;
      ST_READ:    state_next = ST_RESULT;
      ST_END_RD:  state_next = ST_END_MUL;
      ST_END_MUL: state_next = ST_END_WR;
      ST_END_WR:  state_next = walk_last ? ST_END_FIN : ST_END_RD;
      ST_END_FIN: state_next = ST_RESULT;
      ST_INIT:    state_next = (walk_idx == ADDR_W'(MAX_NODES - 1)) ? ST_IDLE : ST_INIT;
      ST_RESULT:  state_next = (!m_tvalid || m_tready) ? ST_IDLE : ST_RESULT;
      default:    state_next = ST_IDLE;
    endcase
  end

  // RAM and divider controls
  always_comb begin
    score_we = 1'b0;
    score_wa = walk_idx;
    score_wd = upd_score;
    score_ra = in_lidx;
    acc_we   = 1'b0;
    acc_wa   = walk_idx;
    acc_wd   = '0;
    acc_ra   = in_diff[ADDR_W-1:0];
    div_req.start    = (state == ST_SCORE);
    div_req.dividend = score_rd;
    div_req.divisor  = r_degree;
    case (state)
      ST_DIV: begin
        acc_ra = r_diff[ADDR_W-1:0];
      end
      ST_ACC: begin
        acc_we = 1'b1;
        acc_wa = acc_idx;
        acc_wd = acc_sat;
      end
      ST_END_RD: begin
        acc_ra = walk_idx;
      end
      ST_END_WR: begin
        score_we = 1'b1;
        acc_we   = 1'b1;
      end
      ST_INIT: begin
        score_we = 1'b1;
        score_wd = {1'b0, initial_score_q30};
        acc_we   = 1'b1;
      end
      default: begin
        acc_we = 1'b0;
      end
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      my_partition      <= 8'd0;
      first_node        <= 32'd0;
      node_count        <= NCOUNT_W'(4096);
      damping_q16       <= 16'd9830;
      teleport_q30      <= 31'd0;
      initial_score_q30 <= 31'd0;
      max_iterations    <= 16'd10;
      iteration_count   <= 16'd0;
      m_tvalid          <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MY_PARTITION:  my_partition      <= cfg_data[7:0];
          CFG_FIRST_NODE:    first_node        <= cfg_data;
          CFG_NODE_COUNT:    node_count        <= cfg_data[NCOUNT_W-1:0];
          CFG_DAMPING:       damping_q16       <= cfg_data[15:0];
          CFG_TELEPORT:      teleport_q30      <= cfg_data[30:0];
          CFG_INITIAL_SCORE: initial_score_q30 <= cfg_data[30:0];
          CFG_MAX_ITER:      max_iterations    <= cfg_data[15:0];
          default:           my_partition      <= my_partition;
        endcase
      end
      if (state == ST_END_FIN) begin
        iteration_count <= iter_inc;
      end
      // Hand the pending result to the output register
      if (state == ST_RESULT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Walk counter for end of iteration and initialise
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_idx <= '0;
    end else if (accept) begin
      walk_idx <= '0;
    end else if (state == ST_END_WR || state == ST_INIT) begin
      walk_idx <= walk_idx + 1'b1;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      r_degree <= in_degree;
      r_tnode  <= in_tnode;
      r_tpart  <= in_tpart;
      acc_idx  <= in_diff[ADDR_W-1:0];
      add_amt  <= in_imp;
      res_kind <= KIND_READ;
      res_part <= 8'd0;
      res_node <= 32'd0;
      res_value <= 32'd0;
      res_more <= 1'b0;
    end
    if (state == ST_DIV && div_rsp.done) begin
      acc_idx   <= r_diff[ADDR_W-1:0];
      add_amt   <= div_rsp.quotient;
      res_kind  <= KIND_REMOTE;
      res_part  <= r_tpart;
      res_node  <= r_tnode;
      res_value <= div_rsp.quotient;
    end
    if (state == ST_READ) begin
      res_kind  <= KIND_READ;
      res_value <= score_rd;
    end
    if (state == ST_END_MUL) begin
      prod <= acc_rd * keep;
    end
    if (state == ST_END_FIN) begin
      res_kind  <= KIND_DONE;
      res_value <= 32'd0;
      res_more  <= iter_inc < max_iterations;
    end
    if (state == ST_RESULT && (!m_tvalid || m_tready)) begin
      m_tuser <= res_kind;
      m_tdata <= {7'd0, res_more, res_value, res_node, res_part};
    end
  end

  ppe_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_NODES)) u_score_ram (
    .clk   (clk),
    .we    (score_we),
    .waddr (score_wa),
    .wdata (score_wd),
    .raddr (score_ra),
    .rdata (score_rd)
  );

  ppe_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_NODES)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_wa),
    .wdata (acc_wd),
    .raddr (acc_ra),
    .rdata (acc_rd)
  );

  ppe_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule
`default_nettype wire

>>> rtl/ppe_checker.sv
// Port-level checker for the partition engine and its bind.
`default_nettype none
`include "pagerank_partition_engine_macros.svh"
module ppe_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic [ppe_pkg::OUT_DATA_W-1:0] m_tdata,
  input wire logic [1:0]                     m_tuser,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready
);
  import ppe_pkg::*;

  // A stalled result holds
  `PPE_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // Reset drops the output
  `PPE_ASSERT_NEXT(a_reset, clk, 1'b0, rst, !m_tvalid)
  // Only defined kinds appear
  `PPE_ASSERT_IMPLY(a_kind, clk, rst, m_tvalid, m_tuser != 2'd3)
  // Destination fields are zero except on remote contributions
  `PPE_ASSERT_IMPLY(a_dest, clk, rst, m_tvalid && m_tuser != KIND_REMOTE, m_tdata[39:0] == 40'd0)
  // The more flag appears only on iteration done
  `PPE_ASSERT_IMPLY(a_more, clk, rst, m_tvalid && m_tuser != KIND_DONE, !m_tdata[72])

endmodule

bind pagerank_partition_engine ppe_checker u_ppe_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
`default_nettype wire
